// ----- rtl/boas_pkg.sv -----
// ----------------------------------------------------------------------------
// boas_pkg
// Shared types and constants for the blob obstacle avoidance steering core.
// ----------------------------------------------------------------------------
package boas_pkg;

   // default camera frame
   localparam int unsigned IMAGE_WIDTH_DEF  = 320;
   localparam int unsigned IMAGE_HEIGHT_DEF = 240;

   // field widths
   localparam int unsigned PIX_W      = 10;
   localparam int unsigned THR_W      = 17;
   localparam int unsigned SPEED_W    = 12;
   localparam int unsigned GAIN_W     = 20;
   localparam int unsigned DECAY_W    = 16;
   localparam int unsigned STRENGTH_W = 25;
   localparam int unsigned YAW_W      = 16;
   localparam int unsigned Q8_SHIFT   = 8;
   localparam int unsigned Q16_SHIFT  = 16;

   // register port
   localparam int unsigned ADDR_W = 5;
   localparam int unsigned DATA_W = 32;

   // register reset values
   localparam logic [THR_W-1:0]   THR_RST   = THR_W'(384);
   localparam logic [SPEED_W-1:0] CRUISE_RST = SPEED_W'(600);
   localparam logic [SPEED_W-1:0] EVADE_RST = SPEED_W'(200);
   localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(13107);
   localparam logic [DECAY_W-1:0] DECAY_RST = DECAY_W'(58982);

   localparam logic [STRENGTH_W-1:0] STRENGTH_MAX = '1;

   typedef enum logic [2:0] {
      REG_ENTER_THRESHOLD = 3'd0,
      REG_CRUISE_SPEED    = 3'd1,
      REG_EVADE_SPEED     = 3'd2,
      REG_STEER_GAIN      = 3'd3,
      REG_DECAY_FACTOR    = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_FORWARD = 2'b01,
      MODE_AVOID   = 2'b10
   } mode_type;

   localparam logic ACTION_DETECT = 1'b0;
   localparam logic ACTION_TICK   = 1'b1;

   localparam logic STEER_HOLD = 1'b0;
   localparam logic STEER_YAW  = 1'b1;

   typedef struct packed {
      logic [THR_W-1:0]   enter_threshold_area;
      logic [SPEED_W-1:0] cruise_speed_mm_s;
      logic [SPEED_W-1:0] evade_speed_mm_s;
      logic [GAIN_W-1:0]  steer_gain_per_pixel;
      logic [DECAY_W-1:0] decay_factor_q16;
   } cfg_type;

endpackage

// ----- rtl/blob_obstacle_avoid_steering_core.sv -----
// ----------------------------------------------------------------------------
// blob_obstacle_avoid_steering_core
// Blob-area obstacle detector and forward/avoid steering state machine.
// ----------------------------------------------------------------------------
// Takes one detection or tick beat per cycle while req_stall is low, with no
// bubbles: each item is captured in an input register and resolved against
// the strength, kept-x and mode state, and any result passes from there into
// the result register that drives rsp (one multiply per path: blob
// area, steering gain times offset, strength decay). Only guided ticks make a
// result, and not the tick that switches into avoidance. rsp is a registered
// output; while a result is stalled the input register still takes one more
// beat, and req_stall then stays high until the waiting result is taken.
module blob_obstacle_avoid_steering_core #(
   parameter int unsigned IMAGE_WIDTH  = boas_pkg::IMAGE_WIDTH_DEF,
   parameter int unsigned IMAGE_HEIGHT = boas_pkg::IMAGE_HEIGHT_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,

   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_action,
   input  logic [boas_pkg::PIX_W-1:0]              req_blob_x,
   input  logic [boas_pkg::PIX_W-1:0]              req_blob_width,
   input  logic [boas_pkg::PIX_W-1:0]              req_blob_height,
   input  logic                                    req_guided_mode,

   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_steer_mode,
   output logic [boas_pkg::SPEED_W-1:0]            rsp_speed_mm_s,
   output logic signed [boas_pkg::YAW_W-1:0]       rsp_yaw_rate_q12,
   output logic                                    rsp_avoiding,

   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [boas_pkg::ADDR_W-1:0]             paddr,
   input  logic [boas_pkg::DATA_W-1:0]             pwdata,
   output logic [boas_pkg::DATA_W-1:0]             prdata,
   output logic                                    pready
);

   localparam int unsigned PIX_W      = boas_pkg::PIX_W;
   localparam int unsigned STRENGTH_W = boas_pkg::STRENGTH_W;
   localparam int unsigned FRAME_AREA = IMAGE_WIDTH * IMAGE_HEIGHT;
   localparam int unsigned AREA_W     = $clog2(FRAME_AREA + 1);
   localparam int unsigned PROD_A_W   = 2 * PIX_W;
   localparam int unsigned CMP_W      = (AREA_W > PROD_A_W) ? AREA_W : PROD_A_W;
   localparam int unsigned AQ8_W      = AREA_W + boas_pkg::Q8_SHIFT;
   localparam int unsigned SAT_W      = (AQ8_W > STRENGTH_W) ? AQ8_W : STRENGTH_W;
   localparam int unsigned OFF_W      = PIX_W + 2;
   localparam int unsigned PROD_W     = boas_pkg::GAIN_W + 1 + OFF_W;
   localparam int unsigned DEC_W      = STRENGTH_W + boas_pkg::DECAY_W;

   localparam logic [PIX_W-1:0]         HALF_WIDTH = PIX_W'(IMAGE_WIDTH / 2);
   localparam logic [CMP_W-1:0]         FRAME_CMP  = CMP_W'(FRAME_AREA);
   localparam logic [AREA_W-1:0]        FRAME_CAP  = AREA_W'(FRAME_AREA);
   localparam logic signed [PROD_W-1:0] YAW_HI = PROD_W'(2 ** (boas_pkg::YAW_W - 1) - 1);
   localparam logic signed [PROD_W-1:0] YAW_LO = -YAW_HI - PROD_W'(1);
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(2 ** (boas_pkg::Q8_SHIFT - 1));

   boas_pkg::cfg_type cfg;

   boas_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // input register
   logic             in_valid_ff,  in_valid_in;
   logic             in_action_ff;
   logic [PIX_W-1:0] in_x_ff;
   logic [PIX_W-1:0] in_w_ff;
   logic [PIX_W-1:0] in_h_ff;
   logic             in_guided_ff;

   // block state
   boas_pkg::mode_type     mode_ff,     mode_in;
   logic [STRENGTH_W-1:0]  strength_ff, strength_in;
   logic [PIX_W-1:0]       kept_x_ff,   kept_x_in;

   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_mode_ff,  rsp_mode_in;
   logic [boas_pkg::SPEED_W-1:0]       rsp_speed_ff, rsp_speed_in;
   logic signed [boas_pkg::YAW_W-1:0]  rsp_yaw_ff,   rsp_yaw_in;
   logic                               rsp_avoid_ff, rsp_avoid_in;

   logic                   out_free;
   logic                   fire;
   logic                   emit;
   logic                   take_req;
   logic                   mode_is_avoid;

   logic [PROD_A_W-1:0]    area_prod;
   logic [AREA_W-1:0]      area_capped;
   logic [SAT_W-1:0]       aq8;
   logic [STRENGTH_W-1:0]  aq8_sat;
   logic                   detect_hit;

   logic [STRENGTH_W-1:0]  thr_q8;
   logic [STRENGTH_W-1:0]  thr_half;
   logic                   enter_avoid;
   logic                   leave_avoid;

   logic signed [OFF_W-1:0]           neg_off;
   logic signed [PROD_W-1:0]          yaw_prod;
   logic signed [PROD_W-1:0]          yaw_shift;
   logic signed [boas_pkg::YAW_W-1:0] yaw_sat;

   logic [DEC_W-1:0]       decay_prod;
   logic [STRENGTH_W-1:0]  decayed;

   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign fire          = in_valid_ff && out_free;
   assign req_stall     = in_valid_ff && !out_free;
   assign take_req      = req_valid && !req_stall;
   assign mode_is_avoid = (mode_ff == boas_pkg::MODE_AVOID);

   // detection path: capped area in q8, saturated to the strength width
   always_comb begin
      area_prod = in_w_ff * in_h_ff;
      if (CMP_W'(area_prod) > FRAME_CMP) begin
         area_capped = FRAME_CAP;
      end else begin
         area_capped = AREA_W'(area_prod);
      end
      aq8 = SAT_W'({area_capped, boas_pkg::Q8_SHIFT'(0)});
      if (aq8 > SAT_W'(boas_pkg::STRENGTH_MAX)) begin
         aq8_sat = boas_pkg::STRENGTH_MAX;
      end else begin
         aq8_sat = aq8[STRENGTH_W-1:0];
      end
      detect_hit = (in_w_ff != '0) && (in_h_ff != '0) && (aq8_sat > strength_ff);
   end

   assign thr_q8      = {cfg.enter_threshold_area, 8'd0};
   assign thr_half    = {1'b0, cfg.enter_threshold_area, 7'd0};
   assign enter_avoid = strength_ff > thr_q8;
   assign leave_avoid = strength_ff < thr_half;

   // yaw = gain * (centre - x), q20 to q12 rounding half up, then saturate
   always_comb begin
      neg_off   = $signed({2'b00, HALF_WIDTH}) - $signed({2'b00, kept_x_ff});
      yaw_prod  = $signed({1'b0, cfg.steer_gain_per_pixel}) * neg_off;
      yaw_shift = (yaw_prod + ROUND_HALF) >>> boas_pkg::Q8_SHIFT;
      if (yaw_shift > YAW_HI) begin
         yaw_sat = YAW_HI[boas_pkg::YAW_W-1:0];
      end else if (yaw_shift < YAW_LO) begin
         yaw_sat = YAW_LO[boas_pkg::YAW_W-1:0];
      end else begin
         yaw_sat = yaw_shift[boas_pkg::YAW_W-1:0];
      end
   end

   assign decay_prod = strength_ff * cfg.decay_factor_q16;
   assign decayed    = decay_prod[DEC_W-1:boas_pkg::Q16_SHIFT];

   always_comb begin
      mode_in      = mode_ff;
      strength_in  = strength_ff;
      kept_x_in    = kept_x_ff;
      emit         = 1'b0;
      rsp_mode_in  = boas_pkg::STEER_HOLD;
      rsp_speed_in = cfg.cruise_speed_mm_s;
      rsp_yaw_in   = '0;
      rsp_avoid_in = 1'b0;
      if (fire) begin
         if (in_action_ff == boas_pkg::ACTION_DETECT) begin
            if (detect_hit) begin
               strength_in = aq8_sat;
               kept_x_in   = in_x_ff;
            end
         end else if (in_guided_ff) begin
            unique case (mode_ff)
               boas_pkg::MODE_FORWARD: begin
                  if (enter_avoid) begin
                     // switch tick: no command and no decay
                     mode_in = boas_pkg::MODE_AVOID;
                  end else begin
                     emit        = 1'b1;
                     strength_in = decayed;
                  end
               end
               boas_pkg::MODE_AVOID: begin
                  emit         = 1'b1;
                  strength_in  = decayed;
                  rsp_mode_in  = boas_pkg::STEER_YAW;
                  rsp_speed_in = cfg.evade_speed_mm_s;
                  rsp_yaw_in   = yaw_sat;
                  rsp_avoid_in = !leave_avoid;
                  if (leave_avoid) begin
                     mode_in = boas_pkg::MODE_FORWARD;
                  end
               end
               default: begin
                  mode_in = boas_pkg::MODE_FORWARD;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = fire && emit;
      end
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= boas_pkg::MODE_FORWARD;
         strength_ff  <= '0;
         kept_x_ff    <= HALF_WIDTH;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         strength_ff  <= strength_in;
         kept_x_ff    <= kept_x_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_action_ff <= req_action;
         in_x_ff      <= req_blob_x;
         in_w_ff      <= req_blob_width;
         in_h_ff      <= req_blob_height;
         in_guided_ff <= req_guided_mode;
      end
      if (fire && emit) begin
         rsp_mode_ff  <= rsp_mode_in;
         rsp_speed_ff <= rsp_speed_in;
         rsp_yaw_ff   <= rsp_yaw_in;
         rsp_avoid_ff <= rsp_avoid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_steer_mode   = rsp_mode_ff;
   assign rsp_speed_mm_s   = rsp_speed_ff;
   assign rsp_yaw_rate_q12 = rsp_yaw_ff;
   assign rsp_avoiding     = rsp_avoid_ff;

   // still avoiding after a step only happens on a yaw command
   a_avoid_implies_yaw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_avoiding |-> rsp_steer_mode == boas_pkg::STEER_YAW)
      else $error("avoiding result without yaw command");

   // heading hold carries no yaw
   a_hold_zero_yaw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_steer_mode == boas_pkg::STEER_HOLD |-> rsp_yaw_rate_q12 == '0)
      else $error("heading hold with nonzero yaw");

   // the tick that enters avoidance does not decay the strength
   a_enter_no_decay: assert property (@(posedge clock) disable iff (reset)
      $rose(mode_is_avoid) |-> $stable(strength_ff))
      else $error("strength changed on avoid entry");

   // a result is only launched from a guided tick
   a_result_from_tick: assert property (@(posedge clock) disable iff (reset)
      fire && emit |-> in_action_ff == boas_pkg::ACTION_TICK && in_guided_ff)
      else $error("result launched from a non-tick item");

endmodule

// ----- rtl/boas_regs.sv -----
// ----------------------------------------------------------------------------
// boas_regs
// Configuration register file behind a simple APB-style slave port.
// ----------------------------------------------------------------------------
module boas_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [boas_pkg::ADDR_W-1:0]      paddr,
   input  logic [boas_pkg::DATA_W-1:0]      pwdata,
   output logic [boas_pkg::DATA_W-1:0]      prdata,
   output logic                             pready,
   output boas_pkg::cfg_type                cfg
);

   boas_pkg::cfg_type       cfg_ff;
   boas_pkg::cfg_type       cfg_in;
   boas_pkg::reg_index_type reg_index;
   logic                    wr_en;

   assign reg_index = boas_pkg::reg_index_type'(paddr[boas_pkg::ADDR_W-1:2]);
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            boas_pkg::REG_ENTER_THRESHOLD: begin
               cfg_in.enter_threshold_area = pwdata[boas_pkg::THR_W-1:0];
            end
            boas_pkg::REG_CRUISE_SPEED: begin
               cfg_in.cruise_speed_mm_s = pwdata[boas_pkg::SPEED_W-1:0];
            end
            boas_pkg::REG_EVADE_SPEED: begin
               cfg_in.evade_speed_mm_s = pwdata[boas_pkg::SPEED_W-1:0];
            end
            boas_pkg::REG_STEER_GAIN: begin
               cfg_in.steer_gain_per_pixel = pwdata[boas_pkg::GAIN_W-1:0];
            end
            boas_pkg::REG_DECAY_FACTOR: begin
               cfg_in.decay_factor_q16 = pwdata[boas_pkg::DECAY_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         boas_pkg::REG_ENTER_THRESHOLD: begin
            prdata = boas_pkg::DATA_W'(cfg_ff.enter_threshold_area);
         end
         boas_pkg::REG_CRUISE_SPEED: begin
            prdata = boas_pkg::DATA_W'(cfg_ff.cruise_speed_mm_s);
         end
         boas_pkg::REG_EVADE_SPEED: begin
            prdata = boas_pkg::DATA_W'(cfg_ff.evade_speed_mm_s);
         end
         boas_pkg::REG_STEER_GAIN: begin
            prdata = boas_pkg::DATA_W'(cfg_ff.steer_gain_per_pixel);
         end
         boas_pkg::REG_DECAY_FACTOR: begin
            prdata = boas_pkg::DATA_W'(cfg_ff.decay_factor_q16);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enter_threshold_area <= boas_pkg::THR_RST;
         cfg_ff.cruise_speed_mm_s    <= boas_pkg::CRUISE_RST;
         cfg_ff.evade_speed_mm_s     <= boas_pkg::EVADE_RST;
         cfg_ff.steer_gain_per_pixel <= boas_pkg::GAIN_RST;
         cfg_ff.decay_factor_q16     <= boas_pkg::DECAY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
